@@ rtl/core/s2dec_pkg.sv @@
// ----------------------------------------------------------------------------
// s2dec_pkg
// Shared types and constants for the signed integer to decimal text block.
// ----------------------------------------------------------------------------
`default_nettype none

package s2dec_pkg;

   // Operand and text geometry
   localparam int unsigned MAG_W      = 32;
   localparam int unsigned NUM_DIGITS = 10;
   localparam int unsigned DIGIT_W    = 4;
   localparam int unsigned IDX_W      = 4;
   localparam int unsigned STEP_W     = 5;
   localparam int unsigned CHAR_W     = 8;

   // Last shift-add-3 step of the binary to BCD conversion
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MAG_W - 1);

   // ASCII codes
   localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

   // Controller to datapath commands
   typedef struct packed {
      logic load;        // capture a new request, start conversion
      logic shift;       // one shift-add-3 step
      logic find;        // locate the most significant nonzero digit
      logic emit_sign;   // drive '-' into the output register
      logic emit_digit;  // drive the current digit, step down one digit
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic conv_done;   // current shift step is the final one
      logic neg;         // request was negative
      logic last_digit;  // current digit is the least significant one
      logic out_free;    // output register can take a character this cycle
   } status_type;

endpackage : s2dec_pkg

`default_nettype wire

@@ rtl/core/s2dec_dp.sv @@
// ----------------------------------------------------------------------------
// s2dec_dp
// Datapath: magnitude, double-dabble BCD register, digit pointer and the
// registered output character.
// ----------------------------------------------------------------------------
`default_nettype none

module s2dec_dp (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic signed [31:0]                  req_value,
   input  wire s2dec_pkg::cmd_type                  cmd,
   output s2dec_pkg::status_type                    status,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [7:0]                               rsp_text_char,
   output logic                                     rsp_last_char
);
   import s2dec_pkg::*;

   logic [MAG_W-1:0]                    mag_ff, mag_in;
   logic [NUM_DIGITS-1:0][DIGIT_W-1:0]  bcd_ff, bcd_in;
   logic [NUM_DIGITS-1:0][DIGIT_W-1:0]  adj;
   logic [NUM_DIGITS*DIGIT_W-1:0]       adj_flat;
   logic [STEP_W-1:0]                   step_ff, step_in;
   logic [IDX_W-1:0]                    idx_ff, idx_in;
   logic [IDX_W-1:0]                    msd;
   logic                                neg_ff, neg_in;
   logic [MAG_W-1:0]                    word;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]                   text_ff, text_in;
   logic                                last_ff, last_in;
   logic                                out_free;

   assign word     = req_value;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         adj[i] = (bcd_ff[i] >= 4'd5) ? bcd_ff[i] + 4'd3 : bcd_ff[i];
      end
   end
   assign adj_flat = adj;

   // Most significant nonzero digit, zero when all digits are zero
   always_comb begin
      msd = '0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[i] != '0) begin
            msd = IDX_W'(i);
         end
      end
   end

   // Conversion registers
   always_comb begin
      mag_in  = mag_ff;
      bcd_in  = bcd_ff;
      step_in = step_ff;
      neg_in  = neg_ff;
      idx_in  = idx_ff;
      if (cmd.load) begin
         neg_in  = word[MAG_W-1];
         mag_in  = word[MAG_W-1] ? (MAG_W'(0) - word) : word;
         bcd_in  = '0;
         step_in = '0;
      end else if (cmd.shift) begin
         bcd_in  = {adj_flat[NUM_DIGITS*DIGIT_W-2:0], mag_ff[MAG_W-1]};
         mag_in  = {mag_ff[MAG_W-2:0], 1'b0};
         step_in = step_ff + 1'b1;
      end else if (cmd.find) begin
         idx_in  = msd;
      end else if (cmd.emit_digit) begin
         idx_in  = idx_ff - 1'b1;
      end
   end

   // Output register
   always_comb begin
      text_in      = text_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.emit_sign) begin
         text_in      = ASCII_MINUS;
         last_in      = 1'b0;
         rsp_valid_in = 1'b1;
      end else if (cmd.emit_digit) begin
         text_in      = ASCII_ZERO + CHAR_W'(bcd_ff[idx_ff]);
         last_in      = (idx_ff == '0);
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      mag_ff  <= mag_in;
      bcd_ff  <= bcd_in;
      step_ff <= step_in;
      neg_ff  <= neg_in;
      idx_ff  <= idx_in;
      text_ff <= text_in;
      last_ff <= last_in;
   end

   assign status.conv_done  = (step_ff == LAST_STEP);
   assign status.neg        = neg_ff;
   assign status.last_digit = (idx_ff == '0);
   assign status.out_free   = out_free;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_text_char = text_ff;
   assign rsp_last_char = last_ff;

endmodule : s2dec_dp

`default_nettype wire

@@ rtl/core/s2dec_ctrl.sv @@
// ----------------------------------------------------------------------------
// s2dec_ctrl
// Controller: sequences load, conversion, digit search and character output.
// ----------------------------------------------------------------------------
`default_nettype none

module s2dec_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire s2dec_pkg::status_type  status,
   output s2dec_pkg::cmd_type          cmd
);
   import s2dec_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_CONVERT = 5'b00010,
      ST_FIND    = 5'b00100,
      ST_SIGN    = 5'b01000,
      ST_DIGITS  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      req_accept;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd.load = 1'b1;
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            cmd.shift = 1'b1;
            if (status.conv_done) begin
               state_in = ST_FIND;
            end
         end
         ST_FIND: begin
            cmd.find = 1'b1;
            state_in = status.neg ? ST_SIGN : ST_DIGITS;
         end
         ST_SIGN: begin
            if (status.out_free) begin
               cmd.emit_sign = 1'b1;
               state_in      = ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            if (status.out_free) begin
               cmd.emit_digit = 1'b1;
               if (status.last_digit) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // An accepted request always starts a conversion
   a_accept_converts: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_CONVERT))
      else $error("accepted request did not start conversion");

   // Sign is only emitted for negative requests
   a_sign_only_neg: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SIGN) |-> status.neg)
      else $error("sign state reached for non-negative request");

   // The final digit returns the controller to idle
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_digit && status.last_digit) |=> (state_ff == ST_IDLE))
      else $error("controller did not return to idle after last digit");

endmodule : s2dec_ctrl

`default_nettype wire

@@ rtl/core/signed_int_to_decimal_ascii.sv @@
// Sequence: a load, 32 shift-add-3 steps and a leading-digit search come
//   before the first character, then one character a cycle while rsp_stall is low.
// Requests: one at a time, held off by req_stall through the 32-step serial BCD
//   conversion until the last character is in the single output register.
// Reset: synchronous, active high; returns to idle with no result pending.
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Formats a signed 32-bit integer as decimal ASCII text, most significant
// character first, with a last-character flag.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_int_to_decimal_ascii (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [31:0] req_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [7:0]              rsp_text_char,
   output logic                    rsp_last_char
);
   import s2dec_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Control
   s2dec_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath
   s2dec_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_value     (req_value),
      .cmd           (cmd),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_text_char (rsp_text_char),
      .rsp_last_char (rsp_last_char)
   );

endmodule : signed_int_to_decimal_ascii

`default_nettype wire
